// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the rtl files
// every check is sampled on aclk; the first form is muted while reset is held
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check with reset masking
`define RMV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that also holds during reset
`define RMV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hdl/rmvce_pkg.sv =====
`timescale 1ns / 1ps

package rmvce_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_VIDEO_TAG    = 2'd0;
    localparam logic [1:0] REG_BITMAP_TAG   = 2'd1;
    localparam logic [1:0] REG_LIST_TAG     = 2'd2;
    localparam logic [1:0] REG_MOVIE_LENGTH = 2'd3;

    // register reset values (fourcc codes are little endian)
    localparam logic [31:0] VIDEO_TAG_RESET    = 32'h6364_3030;
    localparam logic [31:0] BITMAP_TAG_RESET   = 32'h6264_3030;
    localparam logic [31:0] LIST_TAG_RESET     = 32'h5453_494C;
    localparam logic [31:0] MOVIE_LENGTH_RESET = 32'h0000_0000;

    // size of the skipped list type field
    localparam logic [31:0] LIST_TYPE_BYTES = 32'd4;

    typedef struct packed {
        logic [7:0] stream_byte;
        logic       restart;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       chunk_first;
        logic       chunk_last;
        logic       from_bitmap;
    } out_item_t;

    typedef struct packed {
        logic [31:0] video_tag;
        logic [31:0] bitmap_tag;
        logic [31:0] list_tag;
        logic [31:0] movie_length;
    } cfg_regs_t;

endpackage

// ===== hdl/rmvce_cfg.sv =====
`timescale 1ns / 1ps

module rmvce_cfg
    import rmvce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    output cfg_regs_t   cfg
);

    cfg_regs_t cfg_reg;
    cfg_regs_t cfg_next;

    // register write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                REG_VIDEO_TAG:    cfg_next.video_tag    = cfg_wdata;
                REG_BITMAP_TAG:   cfg_next.bitmap_tag   = cfg_wdata;
                REG_LIST_TAG:     cfg_next.list_tag     = cfg_wdata;
                REG_MOVIE_LENGTH: cfg_next.movie_length = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.video_tag    <= VIDEO_TAG_RESET;
            cfg_reg.bitmap_tag   <= BITMAP_TAG_RESET;
            cfg_reg.list_tag     <= LIST_TAG_RESET;
            cfg_reg.movie_length <= MOVIE_LENGTH_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hdl/rmvce_parser.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmvce_parser
    import rmvce_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_fire,
    input  in_item_t  in_item,
    input  cfg_regs_t cfg,
    output logic      res_valid,
    output out_item_t res_item
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_SKIP    = 2'd2;
    localparam logic [1:0] PH_STOPPED = 2'd3;

    logic [1:0]  phase_reg, phase_next, phase_e;
    logic [2:0]  hc_reg, hc_next, hc_e;
    logic [31:0] tag_reg, tag_next, tag_e;
    logic [31:0] left_reg, left_next, left_e;
    logic        pad_reg, pad_next, pad_e;
    logic        first_reg, first_next, first_e;
    logic        bmp_reg, bmp_next, bmp_e;
    logic [31:0] movie_reg, movie_next, movie_e;

    logic        stop;
    logic [31:0] byte_word;
    logic [31:0] size_word;
    logic        is_list, is_video, is_bitmap;

    // restart clears the parser before this byte is parsed
    always_comb begin
        if (in_item.restart) begin
            phase_e = PH_HEADER;
            hc_e    = 3'd0;
            tag_e   = '0;
            left_e  = '0;
            pad_e   = 1'b0;
            first_e = 1'b0;
            bmp_e   = 1'b0;
            movie_e = cfg.movie_length;
        end else begin
            phase_e = phase_reg;
            hc_e    = hc_reg;
            tag_e   = tag_reg;
            left_e  = left_reg;
            pad_e   = pad_reg;
            first_e = first_reg;
            bmp_e   = bmp_reg;
            movie_e = movie_reg;
        end
    end

    // stop when the movie length is used up at a chunk boundary
    assign stop = (phase_e == PH_STOPPED)
               || ((phase_e == PH_HEADER) && (hc_e == 3'd0) && (movie_e == '0));

    // header byte placed in its little-endian lane
    assign byte_word = 32'(in_item.stream_byte) << {hc_e[1:0], 3'b000};

    // size word after this byte, only meaningful in the size half of the header
    assign size_word = ((hc_e == 3'd4) ? 32'd0 : left_e) | byte_word;

    // tag complete once the size half is being gathered
    assign is_list   = (tag_e == cfg.list_tag);
    assign is_video  = (tag_e == cfg.video_tag);
    assign is_bitmap = (tag_e == cfg.bitmap_tag);

    // per-byte parse step
    always_comb begin
        phase_next = phase_e;
        hc_next    = hc_e;
        tag_next   = tag_e;
        left_next  = left_e;
        pad_next   = pad_e;
        first_next = first_e;
        bmp_next   = bmp_e;
        movie_next = movie_e;
        res_valid  = 1'b0;
        res_item.payload_byte = in_item.stream_byte;
        res_item.chunk_first  = first_e;
        res_item.chunk_last   = (left_e == 32'd1);
        res_item.from_bitmap  = bmp_e;

        if (stop) begin
            phase_next = PH_STOPPED;
        end else begin
            if (movie_e != '0) begin
                movie_next = movie_e - 32'd1;
            end
            case (phase_e)
                PH_HEADER: begin
                    hc_next = hc_e + 3'd1;
                    if (!hc_e[2]) begin
                        tag_next = ((hc_e == 3'd0) ? 32'd0 : tag_e) | byte_word;
                    end else begin
                        left_next = size_word;
                    end
                    // full header gathered
                    if (hc_e == 3'd7) begin
                        if (is_list) begin
                            left_next  = LIST_TYPE_BYTES;
                            pad_next   = 1'b0;
                            phase_next = PH_SKIP;
                        end else if ((is_video || is_bitmap) && (size_word != '0)) begin
                            bmp_next   = !is_video;
                            left_next  = size_word;
                            pad_next   = size_word[0];
                            first_next = 1'b1;
                            phase_next = PH_PAYLOAD;
                        end else begin
                            left_next  = size_word;
                            pad_next   = size_word[0];
                            phase_next = (size_word == '0) ? PH_HEADER : PH_SKIP;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    res_valid  = 1'b1;
                    first_next = 1'b0;
                    left_next  = left_e - 32'd1;
                    if (left_e == 32'd1) begin
                        phase_next = pad_e ? PH_SKIP : PH_HEADER;
                    end
                end
                PH_SKIP: begin
                    if (left_e != '0) begin
                        left_next = left_e - 32'd1;
                    end else begin
                        pad_next = 1'b0;
                    end
                    if ((left_next == '0) && !pad_next) begin
                        phase_next = PH_HEADER;
                    end
                end
                default: begin
                    phase_next = PH_STOPPED;
                end
            endcase
        end
    end

    // parser state, advanced once per accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            hc_reg    <= 3'd0;
            tag_reg   <= '0;
            left_reg  <= '0;
            pad_reg   <= 1'b0;
            first_reg <= 1'b0;
            bmp_reg   <= 1'b0;
            movie_reg <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            hc_reg    <= hc_next;
            tag_reg   <= tag_next;
            left_reg  <= left_next;
            pad_reg   <= pad_next;
            first_reg <= first_next;
            bmp_reg   <= bmp_next;
            movie_reg <= movie_next;
        end
    end

    `RMV_ASSERT(a_payload_has_bytes, (phase_reg == PH_PAYLOAD) |-> (left_reg != '0), "payload phase with no bytes left")
    `RMV_ASSERT(a_first_in_payload, first_reg |-> (phase_reg == PH_PAYLOAD), "first mark pending outside payload")
    `RMV_ASSERT(a_stop_holds, ((phase_reg == PH_STOPPED) && in_fire && !in_item.restart) |=> (phase_reg == PH_STOPPED), "parser left stop without restart")

endmodule

// ===== hdl/rmvce_out_reg.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rmvce_out_reg
    import rmvce_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  logic      res_valid,
    input  out_item_t res_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item,
    output logic      in_fire
);

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    // take a new item when the result slot is empty or draining
    assign s_ready = !valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg && !m_ready;
        if (in_fire && res_valid) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge aclk) begin
        if (in_fire && res_valid) begin
            item_reg <= res_item;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

    `RMV_ASSERT(a_stall_blocks_input, (valid_reg && !m_ready) |-> !s_ready, "input taken while result stalled")

endmodule

// ===== hdl/riff_movi_video_chunk_extractor.sv =====
`timescale 1ns / 1ps
// AVI movi list video chunk extractor.
// Input channel s_*: one movi byte per item, with a restart bit that starts a
// new stream at that byte and loads the remaining length from movie_length.
// Result channel m_*: one payload byte of a video or bitmap chunk per item,
// with first and last marks and a bitmap flag. Header, list type, pad and
// skipped chunk bytes produce no item.
// Config port: cfg_wr_en / cfg_addr / cfg_wdata write the tags and movie
// length; write only while the block is idle.
// A result item shows on m_valid in the cycle after its byte is taken.
// Throughput: one byte per cycle while s_ready is high, set by the single parse
// step between the parser state registers and the result register.
// Reset: tags return to 00dc, 00db and LIST, movie length to zero; nothing is
// parsed until the first restart.
// Stall: while a result waits on m_ready low, s_ready drops; s_ready stays
// high while the result register is empty or being taken.

module riff_movi_video_chunk_extractor
    import rmvce_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_item,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_item,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    cfg_regs_t cfg;
    logic      in_fire;
    logic      res_valid;
    out_item_t res_item;

    // configuration registers
    rmvce_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // header gather and chunk walk
    rmvce_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_item   (s_item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    // result register and flow control
    rmvce_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .res_valid (res_valid),
        .res_item  (res_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .in_fire   (in_fire)
    );

endmodule
